// ===== rtl/ssk_pkg.sv =====
// Shared constants and types for the strongest station keeper.
package ssk_pkg;

    localparam int NUM_SLOTS  = 6;
    localparam int SLOT_W     = $clog2(NUM_SLOTS + 1);
    localparam int LEVEL_W    = 16;
    localparam int FREQ_W     = 16;
    localparam int OUT_SLOT_W = 3;

    typedef logic signed [LEVEL_W-1:0] level_t;
    typedef logic [FREQ_W-1:0]         freq_t;
    typedef logic [SLOT_W-1:0]         slot_idx_t;

    localparam level_t EMPTY_LEVEL = -16'sd255;

    localparam logic OP_CLEAR = 1'b0;
    localparam logic OP_OFFER = 1'b1;

    typedef struct packed {
        logic      valid;
        level_t    lowest;
        slot_idx_t idx;
    } tok_t;

    typedef struct packed {
        logic      clear;
        logic      fill;
        logic      shift;
        slot_idx_t ptr;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_FILL,
        ST_SCAN,
        ST_SHIFT,
        ST_REJECT
    } state_t;

endpackage

// ===== rtl/strongest_station_keeper.sv =====
// Top level: slot chain, sweep sequencer and result register.
//
// Keeps the NUM_SLOTS strongest stations of a sweep in a row of slot cells.
// One request is taken at a time. A clear or an offer into a table that is
// not yet full gives its single result once the result output is free. An offer
// into a full table first walks a search token through the cells, one cell
// per cycle, and the decision is taken when the token leaves the last cell;
// a rejected offer then gives one result, a stored one gives one result per
// cycle from the displaced slot up to slot NUM_SLOTS. A stalled result output
// holds the sequence. A new request is taken once the previous one has
// produced its final result.
module strongest_station_keeper
    import ssk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // signal_level[15:0], station_freq[31:16]
    input  logic [0:0]  s_axis_tuser,   // op[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // slot[2:0], slot_level[18:3], slot_freq[34:19],
                                        // filled[37:35], zero[39:38]
    output logic [0:0]  m_axis_tuser,   // stored[0]
    output logic        m_axis_tlast
);

    state_t    state_reg, state_next;
    slot_idx_t occ_reg, occ_next;
    slot_idx_t ptr_reg, ptr_next;
    logic      inj_reg, inj_next;
    level_t    off_level_reg, off_level_next;
    freq_t     off_freq_reg, off_freq_next;

    logic                  out_valid_reg, out_valid_next;
    logic                  out_stored_reg, out_stored_next;
    logic [OUT_SLOT_W-1:0] out_slot_reg, out_slot_next;
    level_t                out_level_reg, out_level_next;
    freq_t                 out_freq_reg, out_freq_next;
    logic [OUT_SLOT_W-1:0] out_filled_reg, out_filled_next;
    logic                  out_last_reg, out_last_next;

    cell_ctrl_t ctrl;
    level_t     cell_level [NUM_SLOTS];
    freq_t      cell_freq  [NUM_SLOTS];
    level_t     nxt_level  [NUM_SLOTS];
    freq_t      nxt_freq   [NUM_SLOTS];
    tok_t       tok        [NUM_SLOTS+1];

    logic   in_accept;
    logic   out_free;
    logic   full;
    level_t sel_level;
    freq_t  sel_freq;

    assign tok[0].valid  = inj_reg;
    assign tok[0].lowest = off_level_reg;
    assign tok[0].idx    = '0;

    genvar gi;
    generate
        for (gi = 0; gi < NUM_SLOTS; gi++)
        begin : g_cell
            if (gi == NUM_SLOTS - 1)
            begin : g_end
                assign nxt_level[gi] = off_level_reg;
                assign nxt_freq[gi]  = off_freq_reg;
            end
            else
            begin : g_mid
                assign nxt_level[gi] = cell_level[gi+1];
                assign nxt_freq[gi]  = cell_freq[gi+1];
            end

            ssk_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .slot_idx    (SLOT_W'(gi + 1)),
                .ctrl        (ctrl),
                .offer_level (off_level_reg),
                .offer_freq  (off_freq_reg),
                .nxt_level   (nxt_level[gi]),
                .nxt_freq    (nxt_freq[gi]),
                .tok_in      (tok[gi]),
                .level       (cell_level[gi]),
                .freq        (cell_freq[gi]),
                .tok_out     (tok[gi+1])
            );
        end
    endgenerate

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign full          = (occ_reg == SLOT_W'(NUM_SLOTS));

    always_comb
    begin
        sel_level = nxt_level[0];
        sel_freq  = nxt_freq[0];
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (ptr_reg == SLOT_W'(i + 1))
            begin
                sel_level = nxt_level[i];
                sel_freq  = nxt_freq[i];
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        occ_next       = occ_reg;
        ptr_next       = ptr_reg;
        inj_next       = 1'b0;
        off_level_next = off_level_reg;
        off_freq_next  = off_freq_reg;

        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_stored_next = out_stored_reg;
        out_slot_next   = out_slot_reg;
        out_level_next  = out_level_reg;
        out_freq_next   = out_freq_reg;
        out_filled_next = out_filled_reg;
        out_last_next   = out_last_reg;

        ctrl.clear = 1'b0;
        ctrl.fill  = 1'b0;
        ctrl.shift = 1'b0;
        ctrl.ptr   = ptr_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    off_level_next = level_t'(s_axis_tdata[15:0]);
                    off_freq_next  = s_axis_tdata[31:16];
                    if (s_axis_tuser[0] == OP_CLEAR)
                    begin
                        state_next = ST_CLEAR;
                    end
                    else if (!full)
                    begin
                        ptr_next   = occ_reg + SLOT_W'(1);
                        state_next = ST_FILL;
                    end
                    else
                    begin
                        inj_next   = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_CLEAR:
            begin
                if (out_free)
                begin
                    ctrl.clear      = 1'b1;
                    occ_next        = '0;
                    out_valid_next  = 1'b1;
                    out_stored_next = 1'b0;
                    out_slot_next   = '0;
                    out_level_next  = '0;
                    out_freq_next   = '0;
                    out_filled_next = '0;
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            ST_FILL:
            begin
                if (out_free)
                begin
                    ctrl.fill       = 1'b1;
                    occ_next        = ptr_reg;
                    out_valid_next  = 1'b1;
                    out_stored_next = 1'b1;
                    out_slot_next   = OUT_SLOT_W'(ptr_reg);
                    out_level_next  = off_level_reg;
                    out_freq_next   = off_freq_reg;
                    out_filled_next = OUT_SLOT_W'(ptr_reg);
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                if (tok[NUM_SLOTS].valid)
                begin
                    ptr_next = tok[NUM_SLOTS].idx;
                    if (tok[NUM_SLOTS].idx == '0)
                    begin
                        state_next = ST_REJECT;
                    end
                    else
                    begin
                        state_next = ST_SHIFT;
                    end
                end
            end

            ST_REJECT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_stored_next = 1'b0;
                    out_slot_next   = '0;
                    out_level_next  = '0;
                    out_freq_next   = '0;
                    out_filled_next = OUT_SLOT_W'(occ_reg);
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            ST_SHIFT:
            begin
                if (out_free)
                begin
                    ctrl.shift      = 1'b1;
                    out_valid_next  = 1'b1;
                    out_stored_next = 1'b1;
                    out_slot_next   = OUT_SLOT_W'(ptr_reg);
                    out_level_next  = sel_level;
                    out_freq_next   = sel_freq;
                    out_filled_next = OUT_SLOT_W'(occ_reg);
                    out_last_next   = full && (ptr_reg == occ_reg);
                    if (ptr_reg == SLOT_W'(NUM_SLOTS))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + SLOT_W'(1);
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            ptr_reg       <= '0;
            inj_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            ptr_reg       <= ptr_next;
            inj_reg       <= inj_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        off_level_reg  <= off_level_next;
        off_freq_reg   <= off_freq_next;
        out_stored_reg <= out_stored_next;
        out_slot_reg   <= out_slot_next;
        out_level_reg  <= out_level_next;
        out_freq_reg   <= out_freq_next;
        out_filled_reg <= out_filled_next;
        out_last_reg   <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_filled_reg, out_freq_reg, out_level_reg, out_slot_reg};
    assign m_axis_tuser  = out_stored_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// ===== rtl/ssk_cell.sv =====
// One table slot: holds a station and passes the weakest-slot search token on.
module ssk_cell
    import ssk_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  slot_idx_t  slot_idx,
    input  cell_ctrl_t ctrl,
    input  level_t     offer_level,
    input  freq_t      offer_freq,
    input  level_t     nxt_level,
    input  freq_t      nxt_freq,
    input  tok_t       tok_in,
    output level_t     level,
    output freq_t      freq,
    output tok_t       tok_out
);

    level_t level_reg;
    level_t level_next;
    freq_t  freq_reg;
    freq_t  freq_next;
    tok_t   tok_reg;
    tok_t   tok_next;
    logic   hit;

    assign hit = (ctrl.ptr == slot_idx);

    always_comb
    begin
        level_next = level_reg;
        freq_next  = freq_reg;
        if (ctrl.clear)
        begin
            level_next = EMPTY_LEVEL;
        end
        else if (ctrl.fill && hit)
        begin
            level_next = offer_level;
            freq_next  = offer_freq;
        end
        else if (ctrl.shift && hit)
        begin
            level_next = nxt_level;
            freq_next  = nxt_freq;
        end

        tok_next = tok_in;
        if (tok_in.valid && (level_reg < tok_in.lowest))
        begin
            tok_next.lowest = level_reg;
            tok_next.idx    = slot_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= EMPTY_LEVEL;
            tok_reg   <= '0;
        end
        else
        begin
            level_reg <= level_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        freq_reg <= freq_next;
    end

    assign level   = level_reg;
    assign freq    = freq_reg;
    assign tok_out = tok_reg;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the strongest station keeper: directed and random auto-store sweeps.
module tb
    import ssk_pkg::*;
();

    localparam int ITEMS_TOTAL   = 470;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 600000;

    typedef struct packed {
        logic                  stored;
        logic [OUT_SLOT_W-1:0] slot;
        level_t                level;
        freq_t                 freq;
        logic [OUT_SLOT_W-1:0] filled;
        logic                  last;
    } slot_write_t;

    class station_ledger;
        level_t      levels [1:NUM_SLOTS];
        freq_t       freqs  [1:NUM_SLOTS];
        int          occupied;
        slot_write_t awaited [$];
        int          mismatches;
        int          results_seen;
        int          displacements;
        int          rejects;
        int          deepest_shift;

        function new();
            foreach (levels[i])
            begin
                levels[i] = EMPTY_LEVEL;
                freqs[i]  = '0;
            end
            occupied = 0;
        endfunction

        function void push(logic stored, int slot, level_t lvl, freq_t frq, logic last);
            slot_write_t w;
            w.stored = stored;
            w.slot   = OUT_SLOT_W'(slot);
            w.level  = lvl;
            w.freq   = frq;
            w.filled = OUT_SLOT_W'(occupied);
            w.last   = last;
            awaited.push_back(w);
        endfunction

        function void note_request(logic op, level_t lvl, freq_t frq);
            level_t lowest;
            int     victim;
            if (op == OP_CLEAR)
            begin
                occupied = 0;
                foreach (levels[i])
                    levels[i] = EMPTY_LEVEL;
                push(1'b0, 0, '0, '0, 1'b1);
                return;
            end
            if (occupied < NUM_SLOTS)
            begin
                occupied++;
                levels[occupied] = lvl;
                freqs[occupied]  = frq;
                push(1'b1, occupied, lvl, frq, 1'b1);
                return;
            end
            lowest = lvl;
            victim = 0;
            for (int i = 1; i <= NUM_SLOTS; i++)
            begin
                if (levels[i] < lowest)
                begin
                    lowest = levels[i];
                    victim = i;
                end
            end
            if (victim == 0)
            begin
                rejects++;
                push(1'b0, 0, '0, '0, 1'b1);
                return;
            end
            displacements++;
            if (NUM_SLOTS - victim > deepest_shift)
                deepest_shift = NUM_SLOTS - victim;
            for (int i = victim; i < NUM_SLOTS; i++)
            begin
                levels[i] = levels[i+1];
                freqs[i]  = freqs[i+1];
                push(1'b1, i, levels[i], freqs[i], 1'b0);
            end
            levels[NUM_SLOTS] = lvl;
            freqs[NUM_SLOTS]  = frq;
            push(1'b1, NUM_SLOTS, lvl, frq, 1'b1);
        endfunction

        function void report(string tag, slot_write_t want, slot_write_t got);
            mismatches++;
            if (mismatches <= 10)
                $display({"%s at %0t: stored %0b/%0b slot %0d/%0d level %0d/%0d ",
                          "freq %h/%h filled %0d/%0d last %0b/%0b (exp/act)"},
                         tag, $time, want.stored, got.stored, want.slot, got.slot,
                         want.level, got.level, want.freq, got.freq,
                         want.filled, got.filled, want.last, got.last);
        endfunction

        function void check_result(slot_write_t got);
            slot_write_t want;
            results_seen++;
            if (awaited.size() == 0)
            begin
                report("unexpected result", '0, got);
                return;
            end
            want = awaited.pop_front();
            if (got.stored !== want.stored || got.slot !== want.slot ||
                got.level !== want.level || got.freq !== want.freq ||
                got.filled !== want.filled || got.last !== want.last)
                report("mismatch", want, got);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        m_axis_tlast;

    station_ledger ledger;
    bit            calm;
    bit            hold_req;
    int            holds_done;
    int            requests_sent;
    int            cycles = 0;

    strongest_station_keeper dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
    begin : watch_results
        slot_write_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.stored = m_axis_tuser[0];
            got.slot   = m_axis_tdata[2:0];
            got.level  = m_axis_tdata[18:3];
            got.freq   = m_axis_tdata[34:19];
            got.filled = m_axis_tdata[37:35];
            got.last   = m_axis_tlast;
            ledger.check_result(got);
        end
    end

    function automatic int draw_wait();
        if (calm || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 17);
    endfunction

    task automatic send_request(logic op, level_t lvl, freq_t frq);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {frq, lvl};
        do @(posedge clk); while (s_axis_tready !== 1'b1);
        ledger.note_request(op, lvl, frq);
        requests_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (ledger.awaited.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : result_sink
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                holds_done++;
            end
            stall = draw_wait();
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (m_axis_tvalid !== 1'b1);
        end
    end

    initial
    begin : stimulus
        int     sweep;
        int     span;
        int     style;
        level_t lvl;
        ledger        = new();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        calm          = 1'b0;
        hold_req      = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // fill with extremes and a tie, then displace from slots 1, 2, 4 and 6
        send_request(OP_CLEAR,  16'sh0000,        16'h0000);
        send_request(OP_OFFER,  16'sh8000,        16'h0000);
        send_request(OP_OFFER,  16'sh7FFF,        16'hFFFF);
        send_request(OP_OFFER,  level_t'(-255),   16'h1234);
        send_request(OP_OFFER,  level_t'(100),    16'h00FF);
        send_request(OP_OFFER,  level_t'(100),    16'hFF00);
        send_request(OP_OFFER,  level_t'(-1),     16'hAAAA);
        send_request(OP_OFFER,  16'sh8000,        16'h5A5A);
        send_request(OP_OFFER,  level_t'(-32767), 16'h8001);
        send_request(OP_OFFER,  level_t'(-32767), 16'h0001);
        send_request(OP_OFFER,  16'sh7FFF,        16'h5555);
        send_request(OP_OFFER,  level_t'(100),    16'h0F0F);
        send_request(OP_OFFER,  level_t'(0),      16'hF0F0);
        send_request(OP_OFFER,  level_t'(101),    16'h3C3C);
        send_request(OP_OFFER,  level_t'(101),    16'hC3C3);
        send_request(OP_OFFER,  16'sh7FFF,        16'h7777);
        send_request(OP_CLEAR,  16'sh7FFF,        16'hFFFF);
        send_request(OP_OFFER,  level_t'(-255),   16'h4321);
        send_request(OP_OFFER,  level_t'(-300),   16'h9999);
        send_request(OP_CLEAR,  level_t'(0),      16'h0000);
        send_request(OP_CLEAR,  level_t'(-1),     16'hFFFF);
        send_request(OP_OFFER,  16'sh8000,        16'hFFFF);
        drain();

        sweep = 0;
        while (requests_sent < ITEMS_TOTAL)
        begin
            calm = ($urandom_range(0, 4) == 0);
            if (sweep == 2)
                hold_req = 1'b1;
            if ($urandom_range(0, 7) != 0)
                send_request(OP_CLEAR, level_t'($urandom), freq_t'($urandom));
            span  = $urandom_range(3, 24);
            style = $urandom_range(0, 2);
            for (int k = 0; k < span; k++)
            begin
                case (style)
                    0: lvl = level_t'($urandom);
                    1: lvl = level_t'(int'($urandom_range(0, 8)) - 4);
                    default:
                        case ($urandom_range(0, 3))
                            0: lvl = 16'sh8000;
                            1: lvl = 16'sh7FFF;
                            2: lvl = EMPTY_LEVEL;
                            default: lvl = level_t'($urandom);
                        endcase
                endcase
                if ($urandom_range(0, 15) == 0)
                    send_request(OP_CLEAR, lvl, freq_t'($urandom));
                else
                    send_request(OP_OFFER, lvl, freq_t'($urandom));
            end
            if ($urandom_range(0, 5) == 0)
                drain();
            sweep++;
        end
        calm = 1'b0;
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d requests in %0d sweeps: %0d displacing (deepest shift %0d), %0d rejected",
                 requests_sent, sweep, ledger.displacements, ledger.deepest_shift,
                 ledger.rejects);
        $display("%0d results checked, %0d output hold-offs, %0d mismatches",
                 ledger.results_seen, holds_done, ledger.mismatches);
        if (ledger.mismatches == 0 && ledger.awaited.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
